### hw/rtl/exchange_sort_min_max_macros.svh
// ----------------------------------------------------------------------------
// Exchange sort with minimum and maximum: assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef EXCHANGE_SORT_MIN_MAX_MACROS_SVH
`define EXCHANGE_SORT_MIN_MAX_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define ESM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ESM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/esm_pkg.sv
// ----------------------------------------------------------------------------
// Exchange sort with minimum and maximum: package
// Word widths and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package esm_pkg;

  localparam int DATA_W = 32;
  localparam int POS_W  = 6;

  typedef enum logic [7:0] {
    S_LOAD = 8'b0000_0001,
    S_LDI  = 8'b0000_0010,
    S_PASS = 8'b0000_0100,
    S_WRI  = 8'b0000_1000,
    S_MIN  = 8'b0001_0000,
    S_MAX  = 8'b0010_0000,
    S_OUT0 = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

endpackage

`default_nettype wire

### hw/rtl/esm_store.sv
// ----------------------------------------------------------------------------
// Exchange sort with minimum and maximum: element store
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module esm_store
  import esm_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [AW-1:0]            waddr,
  input  wire logic signed [DATA_W-1:0] wdata,
  input  wire logic [AW-1:0]            raddr,
  output logic signed [DATA_W-1:0]      rdata_r
);

  logic signed [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

`default_nettype wire

### hw/rtl/exchange_sort_min_max.sv
// ----------------------------------------------------------------------------
// Exchange sort with minimum and maximum: top level
// Loads a set of signed words, sorts it in place and emits it in order.
// ----------------------------------------------------------------------------
// A word is offered on in_value_in with start high and is taken when busy is
// low. The word with in_last_in high closes the set. Words beyond
// MAX_ELEMENTS are dropped and the set is flagged as overflowed. After the
// closing word the block is busy while it sorts the n stored words in the
// element store: each pass reads position i, then streams the later
// positions through one comparator at one word per cycle, writing back on a
// swap; the streaming is set by the single read port of the store. The
// states S_MIN, S_MAX and S_OUT0 then fetch the minimum and maximum, and n
// results follow on consecutive cycles, each marked by out_strobe for one
// cycle, with the last one flagged by out_last_out.
// The receiver cannot stall; results must be taken as they appear.
// Reset clears the fill count, the overflow flag and the sequencer; the
// store itself is not cleared, as only written entries are ever read.
// ----------------------------------------------------------------------------
`default_nettype none
`include "exchange_sort_min_max_macros.svh"

module exchange_sort_min_max
  import esm_pkg::*;
#(
  parameter int MAX_ELEMENTS = 64
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic signed [DATA_W-1:0] in_value_in,
  input  wire logic                     in_last_in,
  output logic                          out_strobe,
  output logic signed [DATA_W-1:0]      out_sorted_value,
  output logic [POS_W-1:0]              out_position,
  output logic                          out_last_out,
  output logic signed [DATA_W-1:0]      out_smallest,
  output logic signed [DATA_W-1:0]      out_largest,
  output logic                          out_overflowed
);

  localparam int AW = $clog2(MAX_ELEMENTS);
  localparam int CW = $clog2(MAX_ELEMENTS + 1);

  state_t                   state_r, state_nxt;
  logic [CW-1:0]            fill_r, fill_nxt;
  logic [CW-1:0]            n_r, n_nxt;
  logic                     ovf_r, ovf_nxt;
  logic [AW-1:0]            i_r, i_nxt;
  logic [AW-1:0]            pj_r, pj_nxt;
  logic [AW-1:0]            k_r, k_nxt;
  logic signed [DATA_W-1:0] cur_r, cur_nxt;
  logic signed [DATA_W-1:0] lo_r, lo_nxt;
  logic signed [DATA_W-1:0] hi_r, hi_nxt;

  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic signed [DATA_W-1:0] mem_wdata;
  logic [AW-1:0]            mem_raddr;
  logic signed [DATA_W-1:0] mem_rdata;

  logic                     has_room;
  logic [CW-1:0]            count_after;
  logic                     final_out;

  esm_store #(
    .DEPTH (MAX_ELEMENTS),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr   (mem_raddr),
    .rdata_r (mem_rdata)
  );

  assign has_room    = fill_r < CW'(MAX_ELEMENTS);
  assign count_after = has_room ? fill_r + CW'(1) : fill_r;
  assign final_out   = (CW'(k_r) + CW'(1)) == n_r;

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    n_nxt     = n_r;
    ovf_nxt   = ovf_r;
    i_nxt     = i_r;
    pj_nxt    = pj_r;
    k_nxt     = k_r;
    cur_nxt   = cur_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    mem_we    = 1'b0;
    mem_waddr = fill_r[AW-1:0];
    mem_wdata = in_value_in;
    mem_raddr = '0;
    case (state_r)
      S_LOAD: begin
        if (start) begin
          if (has_room) begin
            mem_we   = 1'b1;
            fill_nxt = count_after;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last_in) begin
            n_nxt = count_after;
            i_nxt = '0;
            if (count_after > CW'(1)) begin
              state_nxt = S_LDI;
            end else begin
              state_nxt = S_MIN;
            end
          end
        end
      end
      S_LDI: begin
        cur_nxt   = mem_rdata;
        mem_raddr = i_r + AW'(1);
        pj_nxt    = i_r + AW'(1);
        state_nxt = S_PASS;
      end
      S_PASS: begin
        if (cur_r > mem_rdata) begin
          mem_we    = 1'b1;
          mem_waddr = pj_r;
          mem_wdata = cur_r;
          cur_nxt   = mem_rdata;
        end
        if ((CW'(pj_r) + CW'(1)) < n_r) begin
          mem_raddr = pj_r + AW'(1);
          pj_nxt    = pj_r + AW'(1);
        end else begin
          state_nxt = S_WRI;
        end
      end
      S_WRI: begin
        mem_we    = 1'b1;
        mem_waddr = i_r;
        mem_wdata = cur_r;
        if ((CW'(i_r) + CW'(2)) < n_r) begin
          i_nxt     = i_r + AW'(1);
          mem_raddr = i_r + AW'(1);
          state_nxt = S_LDI;
        end else begin
          state_nxt = S_MIN;
        end
      end
      S_MIN: begin
        mem_raddr = '0;
        state_nxt = S_MAX;
      end
      S_MAX: begin
        lo_nxt    = mem_rdata;
        mem_raddr = AW'(n_r - CW'(1));
        state_nxt = S_OUT0;
      end
      S_OUT0: begin
        hi_nxt    = mem_rdata;
        mem_raddr = '0;
        k_nxt     = '0;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        mem_raddr = k_r + AW'(1);
        if (final_out) begin
          fill_nxt  = '0;
          ovf_nxt   = 1'b0;
          state_nxt = S_LOAD;
        end else begin
          k_nxt = k_r + AW'(1);
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      fill_r  <= '0;
      n_r     <= '0;
      ovf_r   <= 1'b0;
      i_r     <= '0;
      pj_r    <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      n_r     <= n_nxt;
      ovf_r   <= ovf_nxt;
      i_r     <= i_nxt;
      pj_r    <= pj_nxt;
      k_r     <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
  end

  assign busy             = state_r != S_LOAD;
  assign out_strobe       = state_r == S_OUT;
  assign out_sorted_value = mem_rdata;
  assign out_position     = POS_W'(k_r);
  assign out_last_out     = out_strobe && final_out;
  assign out_smallest     = lo_r;
  assign out_largest      = hi_r;
  assign out_overflowed   = ovf_r;

  `ESM_ASSERT_SAME(a_result_in_range, out_strobe,
    (out_smallest <= out_sorted_value) && (out_sorted_value <= out_largest),
    "Result word lies outside the reported minimum and maximum.")
  `ESM_ASSERT_NEXT(a_results_contiguous, out_strobe && !out_last_out, out_strobe,
    "Result stream broke off before the final word.")
  `ESM_ASSERT_NEXT(a_plain_load_silent, start && !busy && !in_last_in,
    !out_strobe && !busy, "A word that does not close the set caused activity.")
  `ESM_ASSERT_NEXT(a_last_frees_block, out_last_out, !busy && !out_overflowed,
    "Block did not return to loading after the final result.")

endmodule

`default_nettype wire
